@@ rtl/core/ospf_pkg.sv @@
`default_nettype none
package ospf_pkg;

  // largest number a build may reach before forcing odd
  localparam int unsigned MAX_NUMBER = 65535;

  localparam int unsigned TABLE_DEPTH = 32768;
  localparam int unsigned IDX_W       = 15;

  typedef struct packed {
    logic [15:0] factor;
    logic [14:0] cof_idx;
  } entry_t;

endpackage
`default_nettype wire

@@ rtl/core/odd_smallest_prime_factor_sieve.sv @@
// channel  | handshake          | word
// ---------+--------------------+------------------------------------------------
// in       | start / busy       | in_req_type, in_limit, in_query_number
// out      | out_valid (strobe) | out_smallest_factor, out_cofactor_index,
//          |                    | out_sieved_max, out_status
//
// a word is taken when start is high and busy is low; one result follows per word
// read: ST_RD, ST_RD_OUT, strobe; rejected read, no-op build: strobed from idle
// build: one write and one read port; clears odd entries above n up to m, then
//   scans each odd number up to m, walks multiples of primes, skipping those up to n
// synchronous active-low reset clears control and the built maximum; the table
//   memory is not cleared, a build clears its new range before sieving
// the receiver cannot stall: out_valid is high for exactly one cycle
`default_nettype none
module odd_smallest_prime_factor_sieve (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_req_type,
  input  wire logic [15:0] in_limit,
  input  wire logic [15:0] in_query_number,
  output logic             out_valid,
  output logic [15:0]      out_smallest_factor,
  output logic [14:0]      out_cofactor_index,
  output logic [15:0]      out_sieved_max,
  output logic             out_status
);
  import ospf_pkg::*;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_RD       = 4'd1;
  localparam logic [3:0] ST_RD_OUT   = 4'd2;
  localparam logic [3:0] ST_CLR      = 4'd3;
  localparam logic [3:0] ST_SCAN_RD  = 4'd4;
  localparam logic [3:0] ST_SCAN_CHK = 4'd5;
  localparam logic [3:0] ST_MARK_RD  = 4'd6;
  localparam logic [3:0] ST_MARK_CHK = 4'd7;

  localparam logic [15:0] CLAMP = (MAX_NUMBER >= 65535) ? 16'hFFFF : 16'(MAX_NUMBER);

  entry_t mem [TABLE_DEPTH];
  entry_t rd_data_r;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  logic [IDX_W-1:0] mem_ra;
  entry_t           mem_wd;

  logic [3:0]  state_r, state_nxt;
  logic [15:0] built_max_r, built_max_nxt;
  logic [14:0] q_idx_r, q_idx_nxt;
  logic [15:0] m_r, m_nxt;
  logic [15:0] n_r, n_nxt;
  logic [16:0] i_r, i_nxt;
  logic [16:0] sq_r, sq_nxt;
  logic [16:0] j_r, j_nxt;
  logic [14:0] c_r, c_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_fac_r, out_fac_nxt;
  logic [14:0] out_cof_r, out_cof_nxt;
  logic [15:0] out_max_r, out_max_nxt;
  logic        out_status_r, out_status_nxt;

  logic [15:0] m_clamp;
  logic [19:0] sq_sum;
  logic [16:0] sq_step;
  logic [16:0] j_step;
  logic        is_old;
  logic        is_prime;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  assign m_clamp = ((in_limit > CLAMP) ? CLAMP : in_limit) | 16'd1;
  assign sq_sum  = {3'b000, sq_r} + {1'b0, i_r, 2'b00} + 20'd4;
  // saturate once the square no longer fits in 17 bits, past any reachable limit
  assign sq_step = (sq_sum[19:17] != 3'b000) ? 17'h1FFFF : sq_sum[16:0];
  assign j_step  = 17'(j_r + {i_r[15:0], 1'b0});
  assign is_old  = (i_r <= {1'b0, n_r});
  assign is_prime = is_old ? (rd_data_r.cof_idx == 15'd0) : (rd_data_r.factor == 16'd0);

  always_comb begin
    state_nxt      = state_r;
    built_max_nxt  = built_max_r;
    q_idx_nxt      = q_idx_r;
    m_nxt          = m_r;
    n_nxt          = n_r;
    i_nxt          = i_r;
    sq_nxt         = sq_r;
    j_nxt          = j_r;
    c_nxt          = c_r;
    out_valid_nxt  = 1'b0;
    out_fac_nxt    = out_fac_r;
    out_cof_nxt    = out_cof_r;
    out_max_nxt    = out_max_r;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;
    mem_wa         = '0;
    mem_wd         = '0;
    mem_ra         = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_req_type) begin
            if (!in_query_number[0] || (in_query_number > built_max_r)) begin
              out_valid_nxt  = 1'b1;
              out_fac_nxt    = '0;
              out_cof_nxt    = '0;
              out_max_nxt    = built_max_r;
              out_status_nxt = 1'b1;
            end else begin
              q_idx_nxt = in_query_number[15:1];
              state_nxt = ST_RD;
            end
          end else if (m_clamp <= built_max_r) begin
            out_valid_nxt  = 1'b1;
            out_fac_nxt    = '0;
            out_cof_nxt    = '0;
            out_max_nxt    = built_max_r;
            out_status_nxt = 1'b0;
          end else begin
            m_nxt     = m_clamp;
            n_nxt     = (built_max_r == 16'd0) ? 16'd1 : built_max_r;
            j_nxt     = {1'b0, n_nxt} + 17'd2;
            mem_we    = 1'b1;
            state_nxt = ST_CLR;
          end
        end
      end
      ST_RD: begin
        mem_ra    = q_idx_r;
        state_nxt = ST_RD_OUT;
      end
      ST_RD_OUT: begin
        out_valid_nxt  = 1'b1;
        out_fac_nxt    = rd_data_r.factor;
        out_cof_nxt    = rd_data_r.cof_idx;
        out_max_nxt    = built_max_r;
        out_status_nxt = 1'b0;
        state_nxt      = ST_IDLE;
      end
      ST_CLR: begin
        if (j_r <= {1'b0, m_r}) begin
          mem_we = 1'b1;
          mem_wa = j_r[15:1];
          j_nxt  = j_r + 17'd2;
        end else begin
          i_nxt     = 17'd3;
          sq_nxt    = 17'd9;
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        if (i_r > {1'b0, m_r}) begin
          built_max_nxt  = m_r;
          out_valid_nxt  = 1'b1;
          out_fac_nxt    = '0;
          out_cof_nxt    = '0;
          out_max_nxt    = m_r;
          out_status_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end else begin
          mem_ra    = i_r[15:1];
          state_nxt = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        if (!is_old && is_prime) begin
          mem_we = 1'b1;
          mem_wa = i_r[15:1];
          mem_wd = '{factor: i_r[15:0], cof_idx: 15'd0};
        end
        if (is_prime && (sq_r <= {1'b0, m_r})) begin
          j_nxt     = sq_r;
          c_nxt     = i_r[15:1];
          state_nxt = ST_MARK_RD;
        end else begin
          i_nxt     = i_r + 17'd2;
          sq_nxt    = sq_step;
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_MARK_RD: begin
        if (j_r > {1'b0, m_r}) begin
          i_nxt     = i_r + 17'd2;
          sq_nxt    = sq_step;
          state_nxt = ST_SCAN_RD;
        end else if (j_r <= {1'b0, n_r}) begin
          // multiple already covered by an earlier build
          j_nxt = j_step;
          c_nxt = c_r + 15'd1;
        end else begin
          mem_ra    = j_r[15:1];
          state_nxt = ST_MARK_CHK;
        end
      end
      ST_MARK_CHK: begin
        if (rd_data_r.factor == 16'd0) begin
          mem_we = 1'b1;
          mem_wa = j_r[15:1];
          mem_wd = '{factor: i_r[15:0], cof_idx: c_r};
        end
        j_nxt     = j_step;
        c_nxt     = c_r + 15'd1;
        state_nxt = ST_MARK_RD;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      built_max_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      built_max_r <= built_max_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_idx_r      <= q_idx_nxt;
    m_r          <= m_nxt;
    n_r          <= n_nxt;
    i_r          <= i_nxt;
    sq_r         <= sq_nxt;
    j_r          <= j_nxt;
    c_r          <= c_nxt;
    out_fac_r    <= out_fac_nxt;
    out_cof_r    <= out_cof_nxt;
    out_max_r    <= out_max_nxt;
    out_status_r <= out_status_nxt;
  end

  assign busy                = (state_r != ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_smallest_factor = out_fac_r;
  assign out_cofactor_index  = out_cof_r;
  assign out_sieved_max      = out_max_r;
  assign out_status          = out_status_r;

`ifndef ASSERT_OFF
  a_max_grows: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> built_max_r >= $past(built_max_r))
    else $error("built maximum decreased");

  a_max_odd: assert property (@(posedge clk) disable iff (!rst_n)
    (built_max_r == 16'd0) || built_max_r[0])
    else $error("built maximum is even and nonzero");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_smallest_factor == 16'd0 && out_cofactor_index == 15'd0)
    else $error("error result carries table data");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("accepted word produced neither work nor result");
`endif

endmodule
`default_nettype wire
